// ===== sv/adm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adm_pkg
// Shared types, constants and helpers for the arcade drive mixer.
// ----------------------------------------------------------------------------
package adm_pkg;

    localparam int AXIS_WIDTH = 16;
    localparam int AXIS_DOWN  = (AXIS_WIDTH > 16) ? AXIS_WIDTH - 16 : 0;
    localparam int AXIS_UP    = (AXIS_WIDTH < 16) ? 16 - AXIS_WIDTH : 0;

    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [14:0] FWD_DB_RST    = 15'd1638;
    localparam logic [14:0] TURN_DB_RST   = 15'd5571;
    localparam logic [15:0] GAIN_RST      = 16'd19497;
    localparam logic [14:0] BIAS_RST      = 15'd6783;
    localparam logic [14:0] REDUCTION_RST = 15'd15729;
    localparam logic [7:0]  RAMP_INIT_RST = 8'd60;
    localparam logic [7:0]  RAMP_HIGH_RST = 8'd40;
    localparam logic [7:0]  RAMP_LOW_RST  = 8'd80;

    localparam logic [15:0] UNITY_Q15 = 16'd32768;

    typedef enum logic [2:0] {
        FUNC_AXES      = 3'd0,
        FUNC_ADD_FWD   = 3'd1,
        FUNC_ADD_TURN  = 3'd2,
        FUNC_LEFT_OFF  = 3'd3,
        FUNC_RIGHT_OFF = 3'd4,
        FUNC_BUTTON    = 3'd5
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FWD_DB    = 4'd0,
        CFG_TURN_DB   = 4'd1,
        CFG_GAIN      = 4'd2,
        CFG_BIAS      = 4'd3,
        CFG_REDUCTION = 4'd4,
        CFG_RAMP_INIT = 4'd5,
        CFG_RAMP_HIGH = 4'd6,
        CFG_RAMP_LOW  = 4'd7
    } cfg_idx_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_FWD,
        OP_GAIN,
        OP_BIAS,
        OP_SQ,
        OP_RED,
        OP_RVAL,
        OP_SCALE,
        OP_TURN,
        OP_UPD,
        OP_MIX
    } dp_op_t;

    typedef struct packed {
        logic [14:0] fwd_db;
        logic [14:0] turn_db;
        logic [15:0] gain;
        logic [14:0] bias;
        logic [14:0] reduction;
        logic [7:0]  ramp_high;
        logic [7:0]  ramp_low;
    } cfg_t;

    typedef struct packed {
        logic       en;
        logic [7:0] value;
    } ramp_wr_t;

    typedef struct packed {
        dp_op_t op;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_full;
        logic trn_act;
    } dp_status_t;

    function automatic logic signed [15:0] axis_q15(input logic signed [AXIS_WIDTH-1:0] raw);
        logic signed [31:0] wide;
        logic signed [31:0] down;
        wide = 32'(raw);
        down = wide >>> AXIS_DOWN;
        return down[15:0] <<< AXIS_UP;
    endfunction

    function automatic logic signed [17:0] sat_state(input logic signed [21:0] v);
        if (v > 22'sd131071)
            return 18'sh1FFFF;
        else if (v < -22'sd131072)
            return 18'sh20000;
        else
            return v[17:0];
    endfunction

    function automatic logic signed [15:0] sat_cmd(input logic signed [19:0] v);
        if (v > 20'sd32767)
            return 16'sh7FFF;
        else if (v < -20'sd32768)
            return 16'sh8000;
        else
            return v[15:0];
    endfunction

endpackage

// ===== sv/arcade_drive_mixer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arcade_drive_mixer
// Fixed-point arcade drive mixer with deadbands, offsets and gear shifting.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. An axis transaction (func 0)
// with the turn axis outside its deadband runs the whole turn path; inside the
// turn deadband it goes from the gain step straight to the mix; every other
// func takes a single update step before the mix. The single shared multiplier
// is stepped by the controller through the forward square, gain, curve square,
// reduction and scale products. The result sits in an output register, so
// the next transaction is accepted while a finished one waits to be taken.
// Configuration writes take effect on the next edge and belong in idle time.
module arcade_drive_mixer
    import adm_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [2:0]                   func,
    input  logic signed [AXIS_WIDTH-1:0] x_axis,
    input  logic signed [AXIS_WIDTH-1:0] y_axis,
    input  logic signed [16:0]           amount,
    input  logic                         button,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [15:0]           left_cmd,
    output logic signed [15:0]           right_cmd,
    output logic                         forward_active,
    output logic                         turn_active,
    output logic                         low_gear,
    output logic [7:0]                   ramp_rate
);

    cfg_t       cfg;
    ramp_wr_t   ramp_wr;
    ctrl_cmd_t  cmd;
    dp_status_t status;

    adm_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .ramp_wr   (ramp_wr)
    );

    adm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    adm_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg            (cfg),
        .ramp_wr        (ramp_wr),
        .func           (func),
        .x_axis         (x_axis),
        .y_axis         (y_axis),
        .amount         (amount),
        .button         (button),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .left_cmd       (left_cmd),
        .right_cmd      (right_cmd),
        .forward_active (forward_active),
        .turn_active    (turn_active),
        .low_gear       (low_gear),
        .ramp_rate      (ramp_rate)
    );

endmodule

// ===== sv/adm_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adm_regs
// Configuration register bank; flags ramp_initial writes for the ramp state.
// ----------------------------------------------------------------------------
module adm_regs
    import adm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg,
    output ramp_wr_t              ramp_wr
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fwd_db    <= FWD_DB_RST;
            cfg_reg.turn_db   <= TURN_DB_RST;
            cfg_reg.gain      <= GAIN_RST;
            cfg_reg.bias      <= BIAS_RST;
            cfg_reg.reduction <= REDUCTION_RST;
            cfg_reg.ramp_high <= RAMP_HIGH_RST;
            cfg_reg.ramp_low  <= RAMP_LOW_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FWD_DB:    cfg_reg.fwd_db    <= cfg_data[14:0];
                CFG_TURN_DB:   cfg_reg.turn_db   <= cfg_data[14:0];
                CFG_GAIN:      cfg_reg.gain      <= cfg_data;
                CFG_BIAS:      cfg_reg.bias      <= cfg_data[14:0];
                CFG_REDUCTION: cfg_reg.reduction <= cfg_data[14:0];
                CFG_RAMP_HIGH: cfg_reg.ramp_high <= cfg_data[7:0];
                CFG_RAMP_LOW:  cfg_reg.ramp_low  <= cfg_data[7:0];
                default:       ;
            endcase
        end
    end

    assign cfg           = cfg_reg;
    assign ramp_wr.en    = cfg_we && (cfg_index == CFG_RAMP_INIT);
    assign ramp_wr.value = cfg_data[7:0];

endmodule

// ===== sv/adm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adm_dp
// Datapath: drive state, shared multiplier, axis shaping and output register.
// ----------------------------------------------------------------------------
module adm_dp
    import adm_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  ctrl_cmd_t                    cmd,
    output dp_status_t                   status,
    input  cfg_t                         cfg,
    input  ramp_wr_t                     ramp_wr,
    input  logic [2:0]                   func,
    input  logic signed [AXIS_WIDTH-1:0] x_axis,
    input  logic signed [AXIS_WIDTH-1:0] y_axis,
    input  logic signed [16:0]           amount,
    input  logic                         button,
    input  logic                         out_ready,
    output logic                         out_valid,
    output logic signed [15:0]           left_cmd,
    output logic signed [15:0]           right_cmd,
    output logic                         forward_active,
    output logic                         turn_active,
    output logic                         low_gear,
    output logic [7:0]                   ramp_rate
);

    // transaction fields
    logic [2:0]         func_reg;
    logic signed [16:0] amt_reg;
    logic               btn_reg;
    logic [15:0]        d_reg;
    logic [15:0]        a_reg;
    logic               fwd_act_reg;
    logic               fwd_neg_reg;
    logic               trn_act_reg;
    logic               trn_neg_reg;

    // drive state
    logic signed [17:0] fwd_spd_reg;
    logic signed [17:0] turn_spd_reg;
    logic signed [17:0] loff_reg;
    logic signed [17:0] roff_reg;
    logic               fwd_flag_reg;
    logic               turn_flag_reg;
    logic               armed_reg;
    logic               gear_low_reg;
    logic [7:0]         ramp_reg;

    // work registers
    logic [36:0]        prod_reg;
    logic [36:0]        prod_next;
    logic [15:0]        absf_reg;
    logic [16:0]        absv_reg;
    logic [19:0]        mag_reg;
    logic [15:0]        r_reg;

    // output register
    logic               out_valid_reg;
    logic signed [15:0] left_reg;
    logic signed [15:0] right_reg;
    logic               fwd_out_reg;
    logic               turn_out_reg;
    logic               gear_out_reg;
    logic [7:0]         ramp_out_reg;

    logic signed [15:0] y_q;
    logic signed [15:0] x_q;
    logic signed [16:0] y_w;
    logic signed [16:0] y_n;
    logic signed [16:0] x_w;
    logic signed [16:0] x_n;
    logic signed [16:0] db_w;
    logic signed [16:0] tdb_w;
    logic               y_pos;
    logic               y_neg;
    logic               x_pos;
    logic               x_neg;
    logic signed [16:0] d_w;
    logic signed [16:0] a_w;

    logic [19:0]        mul_a;
    logic [16:0]        mul_b;
    logic               mul_en;

    logic [15:0]        rf;
    logic signed [17:0] fwd_val;
    logic [17:0]        c_val;
    logic signed [18:0] v_val;
    logic signed [18:0] v_abs;
    logic [15:0]        red_val;
    logic [20:0]        t_val;
    logic signed [21:0] t_sgn;
    logic signed [21:0] fwd_sum;
    logic signed [21:0] turn_sum;
    logic signed [21:0] loff_sum;
    logic signed [21:0] roff_sum;
    logic signed [19:0] left_sum;
    logic signed [19:0] right_sum;

    always_comb
    begin
        y_q   = axis_q15(y_axis);
        x_q   = axis_q15(x_axis);
        y_w   = 17'(y_q);
        x_w   = 17'(x_q);
        y_n   = -y_w;
        x_n   = -x_w;
        db_w  = $signed({2'b00, cfg.fwd_db});
        tdb_w = $signed({2'b00, cfg.turn_db});
        y_pos = (y_w >= db_w);
        y_neg = (y_n >= db_w);
        x_pos = (x_w >= tdb_w);
        x_neg = (x_n >= tdb_w);
        d_w   = y_pos ? (y_w - db_w) : (y_n - db_w);
        a_w   = x_pos ? x_w : x_n;
    end

    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        case (cmd.op)
            OP_FWD:
            begin
                mul_a = {4'b0, d_reg};
                mul_b = {1'b0, d_reg};
            end
            OP_GAIN:
            begin
                mul_a = {4'b0, cfg.gain};
                mul_b = {1'b0, a_reg};
            end
            OP_SQ:
            begin
                mul_a = {3'b0, absv_reg};
                mul_b = absv_reg;
            end
            OP_RED:
            begin
                mul_a = {5'b0, cfg.reduction};
                mul_b = {1'b0, absf_reg};
            end
            OP_SCALE:
            begin
                mul_a = mag_reg;
                mul_b = {1'b0, r_reg};
            end
            default: mul_en = 1'b0;
        endcase
        prod_next = {17'b0, mul_a} * {20'b0, mul_b};
    end

    always_comb
    begin
        rf       = 16'((prod_reg + 37'd16384) >> 15);
        fwd_val  = !fwd_act_reg ? 18'sd0 :
                   fwd_neg_reg  ? -$signed({2'b00, rf}) : $signed({2'b00, rf});
        c_val    = 18'((prod_reg + 37'd8192) >> 14);
        v_val    = $signed({1'b0, c_val}) - $signed({4'b0, cfg.bias});
        v_abs    = (v_val < 0) ? -v_val : v_val;
        red_val  = 16'((prod_reg + 37'd16384) >> 15);
        t_val    = 21'((prod_reg + 37'd16384) >> 15);
        t_sgn    = trn_neg_reg ? -$signed({1'b0, t_val}) : $signed({1'b0, t_val});
        fwd_sum  = 22'(fwd_spd_reg) + 22'(amt_reg);
        turn_sum = 22'(turn_spd_reg) + 22'(amt_reg);
        loff_sum = 22'(loff_reg) + 22'(amt_reg);
        roff_sum = 22'(roff_reg) + 22'(amt_reg);
        left_sum  = 20'(fwd_spd_reg) + 20'(turn_spd_reg) + 20'(loff_reg);
        right_sum = -(20'(fwd_spd_reg) - 20'(turn_spd_reg) + 20'(roff_reg));
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= prod_next;
        case (cmd.op)
            OP_LOAD:
            begin
                func_reg    <= func;
                amt_reg     <= amount;
                btn_reg     <= button;
                d_reg       <= d_w[15:0];
                a_reg       <= a_w[15:0];
                fwd_act_reg <= y_pos || y_neg;
                fwd_neg_reg <= !y_pos;
                trn_act_reg <= x_pos || x_neg;
                trn_neg_reg <= !x_pos;
            end
            OP_GAIN:  absf_reg <= fwd_act_reg ? rf : 16'd0;
            OP_BIAS:  absv_reg <= v_abs[16:0];
            OP_RED:   mag_reg  <= 20'((prod_reg + 37'd16384) >> 15);
            OP_RVAL:  r_reg    <= UNITY_Q15 - red_val;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_spd_reg   <= '0;
            turn_spd_reg  <= '0;
            loff_reg      <= '0;
            roff_reg      <= '0;
            fwd_flag_reg  <= 1'b0;
            turn_flag_reg <= 1'b0;
            armed_reg     <= 1'b0;
            gear_low_reg  <= 1'b0;
            ramp_reg      <= RAMP_INIT_RST;
        end
        else if (ramp_wr.en)
        begin
            ramp_reg <= ramp_wr.value;
        end
        else
        begin
            case (cmd.op)
                OP_GAIN:
                begin
                    fwd_spd_reg   <= fwd_val;
                    fwd_flag_reg  <= fwd_act_reg;
                    turn_flag_reg <= trn_act_reg;
                    loff_reg      <= '0;
                    roff_reg      <= '0;
                    if (!trn_act_reg)
                        turn_spd_reg <= '0;
                end
                OP_TURN: turn_spd_reg <= sat_state(t_sgn);
                OP_UPD:
                begin
                    case (func_reg)
                        FUNC_ADD_FWD:  fwd_spd_reg  <= sat_state(fwd_sum);
                        FUNC_ADD_TURN: turn_spd_reg <= sat_state(turn_sum);
                        FUNC_LEFT_OFF:
                        begin
                            if (amt_reg < 0)
                                loff_reg <= sat_state(loff_sum);
                            else
                                roff_reg <= sat_state(roff_sum);
                        end
                        FUNC_RIGHT_OFF:
                        begin
                            if (amt_reg < 0)
                                roff_reg <= sat_state(roff_sum);
                            else
                                loff_reg <= sat_state(loff_sum);
                        end
                        FUNC_BUTTON:
                        begin
                            if (btn_reg)
                            begin
                                if (armed_reg)
                                begin
                                    gear_low_reg <= !gear_low_reg;
                                    ramp_reg     <= gear_low_reg ? cfg.ramp_high : cfg.ramp_low;
                                    armed_reg    <= 1'b0;
                                end
                            end
                            else
                            begin
                                armed_reg <= 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == OP_MIX)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_MIX)
        begin
            left_reg     <= sat_cmd(left_sum);
            right_reg    <= sat_cmd(right_sum);
            fwd_out_reg  <= fwd_flag_reg;
            turn_out_reg <= turn_flag_reg;
            gear_out_reg <= gear_low_reg;
            ramp_out_reg <= ramp_reg;
        end
    end

    assign status.out_full = out_valid_reg;
    assign status.trn_act  = trn_act_reg;

    assign out_valid      = out_valid_reg;
    assign left_cmd       = left_reg;
    assign right_cmd      = right_reg;
    assign forward_active = fwd_out_reg;
    assign turn_active    = turn_out_reg;
    assign low_gear       = gear_out_reg;
    assign ramp_rate      = ramp_out_reg;

    a_mix_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_MIX |=> out_valid_reg)
        else $error("result register empty after mix");

    a_fwd_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_GAIN && !fwd_act_reg && !ramp_wr.en) |=>
        (fwd_spd_reg == '0 && !fwd_flag_reg))
        else $error("forward speed not cleared inside deadband");

    a_scale_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.op == OP_SCALE |-> r_reg != '0)
        else $error("turn reduction factor reached zero");

endmodule

// ===== sv/adm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adm_ctrl
// Controller: accepts a transaction, sequences the datapath, issues the mix.
// ----------------------------------------------------------------------------
module adm_ctrl
    import adm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] func,
    input  logic       out_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_FWD,
        S_GAIN,
        S_BIAS,
        S_SQ,
        S_RED,
        S_RVAL,
        S_SCALE,
        S_TURN,
        S_UPD,
        S_MIX
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   mix_go;

    assign mix_go = !status.out_full || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = (func == FUNC_AXES) ? S_FWD : S_UPD;
                end
            end
            S_FWD:
            begin
                cmd.op     = OP_FWD;
                state_next = S_GAIN;
            end
            S_GAIN:
            begin
                cmd.op     = OP_GAIN;
                state_next = status.trn_act ? S_BIAS : S_MIX;
            end
            S_BIAS:
            begin
                cmd.op     = OP_BIAS;
                state_next = S_SQ;
            end
            S_SQ:
            begin
                cmd.op     = OP_SQ;
                state_next = S_RED;
            end
            S_RED:
            begin
                cmd.op     = OP_RED;
                state_next = S_RVAL;
            end
            S_RVAL:
            begin
                cmd.op     = OP_RVAL;
                state_next = S_SCALE;
            end
            S_SCALE:
            begin
                cmd.op     = OP_SCALE;
                state_next = S_TURN;
            end
            S_TURN:
            begin
                cmd.op     = OP_TURN;
                state_next = S_MIX;
            end
            S_UPD:
            begin
                cmd.op     = OP_UPD;
                state_next = S_MIX;
            end
            S_MIX:
            begin
                if (mix_go)
                begin
                    cmd.op     = OP_MIX;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == S_IDLE);
        end
    end

    assign in_ready = in_ready_reg;

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready_reg |-> state_reg == S_IDLE)
        else $error("ready outside idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready_reg) |=> !in_ready_reg)
        else $error("second transaction taken while busy");

    a_mix_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MIX && status.out_full && !out_ready) |=> state_reg == S_MIX)
        else $error("result overwritten before it was taken");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the arcade drive mixer. A driver and a monitor
// exchange valid/ready transactions with the block while a shadow copy of the
// mixer state predicts each result and checks it field by field. The run steps
// through several register settings, idling mixes and one long receiver stall.
// ----------------------------------------------------------------------------
module testbench;
    import adm_pkg::*;

    localparam int          CFG_COUNT   = 8;
    localparam logic [2:0]  FUNC_SPARE6 = 3'd6;
    localparam logic [2:0]  FUNC_SPARE7 = 3'd7;

    typedef struct {
        logic [2:0]         fn;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [16:0] amt;
        logic               btn;
    } stick_cmd_t;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic               fwd_act;
        logic               turn_act;
        logic               gear;
        logic [7:0]         ramp;
    } mix_out_t;

    logic                         clk       = 1'b0;
    logic                         rst_n     = 1'b0;
    logic                         cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]         cfg_index = '0;
    logic [CFG_DATA_W-1:0]        cfg_data  = '0;
    logic                         in_valid  = 1'b0;
    logic                         in_ready;
    logic [2:0]                   func      = '0;
    logic signed [AXIS_WIDTH-1:0] x_axis    = '0;
    logic signed [AXIS_WIDTH-1:0] y_axis    = '0;
    logic signed [16:0]           amount    = '0;
    logic                         button    = 1'b0;
    logic                         out_valid;
    logic                         out_ready = 1'b0;
    logic signed [15:0]           left_cmd;
    logic signed [15:0]           right_cmd;
    logic                         forward_active;
    logic                         turn_active;
    logic                         low_gear;
    logic [7:0]                   ramp_rate;

    stick_cmd_t stick_queue[$];
    mix_out_t   mix_expect[$];
    stick_cmd_t on_bus;
    mix_out_t   want;
    int         idle_pct       = 0;
    int         stall_pct      = 0;
    logic       hold_on        = 1'b0;
    event       hold_start;
    int         mismatch_count = 0;

    logic [15:0]        cfg_shadow [1 << CFG_IDX_W];
    logic signed [17:0] fwd_spd    = '0;
    logic signed [17:0] turn_spd   = '0;
    logic signed [17:0] left_off   = '0;
    logic signed [17:0] right_off  = '0;
    logic               fwd_flag   = 1'b0;
    logic               turn_flag  = 1'b0;
    logic               armed      = 1'b0;
    logic               gear_low   = 1'b0;
    logic [7:0]         ramp_val   = RAMP_INIT_RST;

    arcade_drive_mixer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .x_axis         (x_axis),
        .y_axis         (y_axis),
        .amount         (amount),
        .button         (button),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .left_cmd       (left_cmd),
        .right_cmd      (right_cmd),
        .forward_active (forward_active),
        .turn_active    (turn_active),
        .low_gear       (low_gear),
        .ramp_rate      (ramp_rate)
    );

    initial forever #5 clk = ~clk;

    function automatic longint rnd15(longint p);
        return (p + 64'sd16384) >>> 15;
    endfunction

    function automatic logic signed [17:0] clip18(longint v);
        if (v > 131071)
            return 18'sh1FFFF;
        if (v < -131072)
            return 18'sh20000;
        return v[17:0];
    endfunction

    function automatic logic signed [15:0] clip16(longint v);
        if (v > 32767)
            return 16'sh7FFF;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic mix_out_t mix_predict(stick_cmd_t c);
        longint   x, y, amt, db, tdb, d, fwd, a, cv, v, mag, absf, r;
        longint   f, t;
        logic     neg;
        mix_out_t o;
        x   = longint'(c.x);
        y   = longint'(c.y);
        amt = longint'(c.amt);
        db  = longint'(cfg_shadow[CFG_FWD_DB]);
        tdb = longint'(cfg_shadow[CFG_TURN_DB]);
        case (c.fn)
            FUNC_AXES:
            begin
                left_off  = '0;
                right_off = '0;
                if (y >= db)
                begin
                    d        = y - db;
                    fwd      = rnd15(d * d);
                    fwd_flag = 1'b1;
                end
                else if (y <= -db)
                begin
                    d        = -y - db;
                    fwd      = -rnd15(d * d);
                    fwd_flag = 1'b1;
                end
                else
                begin
                    fwd      = 0;
                    fwd_flag = 1'b0;
                end
                fwd_spd = clip18(fwd);
                if (x >= tdb || x <= -tdb)
                begin
                    neg       = !(x >= tdb);
                    a         = neg ? -x : x;
                    turn_flag = 1'b1;
                    cv   = (longint'(cfg_shadow[CFG_GAIN]) * a + 8192) >>> 14;
                    v    = cv - longint'(cfg_shadow[CFG_BIAS]);
                    mag  = rnd15(v * v);
                    absf = longint'(fwd_spd);
                    if (absf < 0)
                        absf = -absf;
                    r = 32768 - rnd15(longint'(cfg_shadow[CFG_REDUCTION]) * absf);
                    if (r < 0)
                        r = 0;
                    mag      = rnd15(mag * r);
                    turn_spd = clip18(neg ? -mag : mag);
                end
                else
                begin
                    turn_flag = 1'b0;
                    turn_spd  = '0;
                end
            end
            FUNC_ADD_FWD:
                fwd_spd = clip18(longint'(fwd_spd) + amt);
            FUNC_ADD_TURN:
                turn_spd = clip18(longint'(turn_spd) + amt);
            FUNC_LEFT_OFF:
            begin
                if (amt < 0)
                    left_off = clip18(longint'(left_off) + amt);
                else
                    right_off = clip18(longint'(right_off) + amt);
            end
            FUNC_RIGHT_OFF:
            begin
                if (amt < 0)
                    right_off = clip18(longint'(right_off) + amt);
                else
                    left_off = clip18(longint'(left_off) + amt);
            end
            FUNC_BUTTON:
            begin
                if (c.btn && armed)
                begin
                    gear_low = !gear_low;
                    ramp_val = gear_low ? cfg_shadow[CFG_RAMP_LOW][7:0]
                                        : cfg_shadow[CFG_RAMP_HIGH][7:0];
                    armed    = 1'b0;
                end
                if (!c.btn && !armed)
                    armed = 1'b1;
            end
            default:
            begin
            end
        endcase
        f = longint'(fwd_spd);
        t = longint'(turn_spd);
        o.left     = clip16(f + t + longint'(left_off));
        o.right    = clip16(-(f - t + longint'(right_off)));
        o.fwd_act  = fwd_flag;
        o.turn_act = turn_flag;
        o.gear     = gear_low;
        o.ramp     = ramp_val;
        return o;
    endfunction

    function automatic logic signed [15:0] rand_axis(longint band);
        longint v;
        case ($urandom_range(5))
            0:
            begin
                v = band + longint'($urandom_range(4)) - 2;
                if ($urandom_range(1))
                    v = -v;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                return v[15:0];
            end
            1:
            begin
                case ($urandom_range(3))
                    0:       return 16'sh7FFF;
                    1:       return 16'sh8000;
                    2:       return 16'sh8001;
                    default: return 16'sh0000;
                endcase
            end
            default:
                return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [16:0] rand_amount();
        longint v;
        case ($urandom_range(3))
            0:
                return $urandom_range(1) ? 17'sh0FFFF : 17'sh10000;
            1:
            begin
                v = longint'($urandom_range(4000)) - 2000;
                return v[16:0];
            end
            default:
                return 17'($urandom);
        endcase
    endfunction

    function automatic stick_cmd_t rand_cmd();
        stick_cmd_t c;
        int         pick;
        c.x   = 16'($urandom);
        c.y   = 16'($urandom);
        c.amt = 17'($urandom);
        c.btn = 1'($urandom);
        pick  = $urandom_range(99);
        if (pick < 40)
        begin
            c.fn = FUNC_AXES;
            c.x  = rand_axis(longint'(cfg_shadow[CFG_TURN_DB]));
            c.y  = rand_axis(longint'(cfg_shadow[CFG_FWD_DB]));
        end
        else if (pick < 74)
        begin
            case (pick % 4)
                0:       c.fn = FUNC_ADD_FWD;
                1:       c.fn = FUNC_ADD_TURN;
                2:       c.fn = FUNC_LEFT_OFF;
                default: c.fn = FUNC_RIGHT_OFF;
            endcase
            c.amt = rand_amount();
        end
        else if (pick < 95)
            c.fn = FUNC_BUTTON;
        else
            c.fn = $urandom_range(1) ? FUNC_SPARE6 : FUNC_SPARE7;
        return c;
    endfunction

    task automatic push_cmd(logic [2:0] fn, logic signed [15:0] x, logic signed [15:0] y,
                            logic signed [16:0] amt, logic btn);
        stick_cmd_t c;
        c.fn  = fn;
        c.x   = x;
        c.y   = y;
        c.amt = amt;
        c.btn = btn;
        stick_queue.push_back(c);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_FWD_DB, CFG_TURN_DB, CFG_BIAS, CFG_REDUCTION:
                cfg_shadow[idx] = {1'b0, val[14:0]};
            CFG_GAIN:
                cfg_shadow[idx] = val;
            CFG_RAMP_INIT, CFG_RAMP_HIGH, CFG_RAMP_LOW:
                cfg_shadow[idx] = {8'h00, val[7:0]};
            default:
            begin
            end
        endcase
        if (idx == CFG_RAMP_INIT)
            ramp_val = val[7:0];
    endtask

    task automatic load_random_cfg(int db_span);
        for (int i = 0; i < CFG_COUNT; i++)
        begin
            if (i == CFG_FWD_DB || i == CFG_TURN_DB)
                write_reg(CFG_IDX_W'(i), 16'($urandom_range(db_span)));
            else
                write_reg(CFG_IDX_W'(i), 16'($urandom));
        end
        write_reg(CFG_IDX_W'($urandom_range(15, CFG_COUNT)), 16'($urandom));
    endtask

    task automatic load_flat_cfg(logic [15:0] val);
        for (int i = 0; i < CFG_COUNT; i++)
            write_reg(CFG_IDX_W'(i), val);
    endtask

    task automatic drain();
        while (stick_queue.size() != 0 || in_valid || mix_expect.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic run_phase(int n, int send_idle, int recv_stall);
        @(negedge clk);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        for (int i = 0; i < n; i++)
            stick_queue.push_back(rand_cmd());
        drain();
    endtask

    // driver: predict at acceptance, then load the next transaction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
                mix_expect.push_back(mix_predict(on_bus));
            if (!in_valid || in_ready)
            begin
                if (stick_queue.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    on_bus   = stick_queue.pop_front();
                    func     <= on_bus.fn;
                    x_axis   <= on_bus.x;
                    y_axis   <= on_bus.y;
                    amount   <= on_bus.amt;
                    button   <= on_bus.btn;
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver hold: keep the receiver off after each hold_start event
    always
    begin
        @(hold_start);
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
    end

    // monitor: compare against the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (mix_expect.size() == 0)
                begin
                    $error("unexpected transaction: left_cmd %0d right_cmd %0d",
                           left_cmd, right_cmd);
                    mismatch_count++;
                end
                else
                begin
                    want = mix_expect.pop_front();
                    if (left_cmd !== want.left)
                    begin
                        $error("left_cmd: expected %0d, got %0d", want.left, left_cmd);
                        mismatch_count++;
                    end
                    if (right_cmd !== want.right)
                    begin
                        $error("right_cmd: expected %0d, got %0d", want.right, right_cmd);
                        mismatch_count++;
                    end
                    if (forward_active !== want.fwd_act)
                    begin
                        $error("forward_active: expected %0d, got %0d",
                               want.fwd_act, forward_active);
                        mismatch_count++;
                    end
                    if (turn_active !== want.turn_act)
                    begin
                        $error("turn_active: expected %0d, got %0d",
                               want.turn_act, turn_active);
                        mismatch_count++;
                    end
                    if (low_gear !== want.gear)
                    begin
                        $error("low_gear: expected %0d, got %0d", want.gear, low_gear);
                        mismatch_count++;
                    end
                    if (ramp_rate !== want.ramp)
                    begin
                        $error("ramp_rate: expected %0d, got %0d", want.ramp, ramp_rate);
                        mismatch_count++;
                    end
                end
            end
            if (hold_on)
                out_ready <= 1'b0;
            else
                out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    initial
    begin
        cfg_shadow[CFG_FWD_DB]    = {1'b0, FWD_DB_RST};
        cfg_shadow[CFG_TURN_DB]   = {1'b0, TURN_DB_RST};
        cfg_shadow[CFG_GAIN]      = GAIN_RST;
        cfg_shadow[CFG_BIAS]      = {1'b0, BIAS_RST};
        cfg_shadow[CFG_REDUCTION] = {1'b0, REDUCTION_RST};
        cfg_shadow[CFG_RAMP_INIT] = {8'h00, RAMP_INIT_RST};
        cfg_shadow[CFG_RAMP_HIGH] = {8'h00, RAMP_HIGH_RST};
        cfg_shadow[CFG_RAMP_LOW]  = {8'h00, RAMP_LOW_RST};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset values, deadband edges, saturation, offsets, gear toggling
        push_cmd(FUNC_SPARE6, 16'sh7FFF, 16'sh8000, 17'sh0FFFF, 1'b1);
        push_cmd(FUNC_AXES, 16'sh0000, 16'sh0000, 17'sh00000, 1'b0);
        push_cmd(FUNC_AXES, 16'sh7FFF, 16'sh7FFF, 17'sh10000, 1'b1);
        push_cmd(FUNC_AXES, 16'sh8000, 16'sh8000, 17'sh00000, 1'b0);
        push_cmd(FUNC_AXES, 16'sd5571, 16'sd1638, 17'sh00000, 1'b0);
        push_cmd(FUNC_AXES, -16'sd5571, -16'sd1638, 17'sh00000, 1'b0);
        push_cmd(FUNC_AXES, 16'sd5570, 16'sd1637, 17'sh00000, 1'b0);
        push_cmd(FUNC_ADD_FWD, 16'sh0000, 16'sh0000, 17'sh0FFFF, 1'b0);
        push_cmd(FUNC_ADD_FWD, 16'sh0000, 16'sh0000, 17'sh0FFFF, 1'b0);
        push_cmd(FUNC_ADD_FWD, 16'sh0000, 16'sh0000, 17'sh0FFFF, 1'b0);
        push_cmd(FUNC_ADD_TURN, 16'sh0000, 16'sh0000, 17'sh10000, 1'b0);
        push_cmd(FUNC_ADD_TURN, 16'sh0000, 16'sh0000, 17'sh10000, 1'b0);
        push_cmd(FUNC_ADD_TURN, 16'sh0000, 16'sh0000, 17'sh10000, 1'b0);
        push_cmd(FUNC_LEFT_OFF, 16'sh0000, 16'sh0000, 17'sh10000, 1'b0);
        push_cmd(FUNC_LEFT_OFF, 16'sh0000, 16'sh0000, 17'sh0FFFF, 1'b0);
        push_cmd(FUNC_RIGHT_OFF, 16'sh0000, 16'sh0000, 17'sh10000, 1'b1);
        push_cmd(FUNC_RIGHT_OFF, 16'sh0000, 16'sh0000, 17'sh0FFFF, 1'b1);
        push_cmd(FUNC_BUTTON, 16'sh0000, 16'sh0000, 17'sh00000, 1'b1);
        push_cmd(FUNC_BUTTON, 16'sh0000, 16'sh0000, 17'sh00000, 1'b0);
        push_cmd(FUNC_BUTTON, 16'sh0000, 16'sh0000, 17'sh00000, 1'b1);
        push_cmd(FUNC_BUTTON, 16'sh0000, 16'sh0000, 17'sh00000, 1'b1);
        push_cmd(FUNC_BUTTON, 16'sh0000, 16'sh0000, 17'sh00000, 1'b0);
        push_cmd(FUNC_BUTTON, 16'sh0000, 16'sh0000, 17'sh00000, 1'b1);
        push_cmd(FUNC_SPARE7, 16'sh8000, 16'sh7FFF, 17'sh10000, 1'b0);
        run_phase(90, 0, 0);

        load_random_cfg(65535);
        run_phase(100, 51, 0);

        load_flat_cfg(16'h0000);
        write_reg(CFG_IDX_W'($urandom_range(15, CFG_COUNT)), 16'hFFFF);
        run_phase(100, 0, 51);

        load_flat_cfg(16'hFFFF);
        run_phase(100, 27, 27);

        // hold off the receiver long enough to back up the input
        write_reg(CFG_FWD_DB, 16'(FWD_DB_RST));
        write_reg(CFG_TURN_DB, 16'(TURN_DB_RST));
        write_reg(CFG_GAIN, GAIN_RST);
        write_reg(CFG_BIAS, 16'(BIAS_RST));
        write_reg(CFG_REDUCTION, 16'(REDUCTION_RST));
        write_reg(CFG_RAMP_INIT, 16'(RAMP_INIT_RST));
        write_reg(CFG_RAMP_HIGH, 16'(RAMP_HIGH_RST));
        write_reg(CFG_RAMP_LOW, 16'(RAMP_LOW_RST));
        @(negedge clk);
        idle_pct  = 0;
        stall_pct = 0;
        for (int i = 0; i < 100; i++)
            stick_queue.push_back(rand_cmd());
        -> hold_start;
        drain();

        load_random_cfg(4000);
        run_phase(110, 27, 27);

        load_random_cfg(65535);
        run_phase(100, 51, 0);

        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && mix_expect.size() == 0)
            $display("[arcade_drive_mixer] OK");
        else
            $display("[arcade_drive_mixer] ERROR");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("[arcade_drive_mixer] ERROR");
        $finish;
    end

endmodule
